[rtl/lmms_pkg.sv]
// types and constants shared by the local maxima mean spacing block
// no dependencies

package lmms_pkg;

  localparam int MEAN_W = 21;

  typedef enum logic [0:0] {
    ST_RUN,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic accept;
    logic start_div;
    logic div_step;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

[rtl/lmms_ctrl.sv]
// controller for the local maxima mean spacing block: handshakes and sequencing
// depends on lmms_pkg

module lmms_ctrl import lmms_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output cmd_t    cmd,
  input  status_t status
);

  state_t state;
  state_t state_next;
  logic   out_full;
  logic   out_full_next;
  logic   in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_RUN;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (in_fire && in_last) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_comb begin
    in_stall        = 1'b1;
    cmd.div_step    = 1'b0;
    cmd.load_result = 1'b0;
    unique case (state)
      ST_RUN: begin
        in_stall = in_last && out_full;
      end
      ST_DIV: begin
        cmd.div_step    = !status.div_done;
        cmd.load_result = status.div_done;
      end
      default: in_stall = 1'b1;
    endcase
    in_fire       = in_valid && !in_stall;
    cmd.accept    = in_fire;
    cmd.start_div = in_fire && in_last;
  end

  always_comb begin
    out_full_next = out_full;
    if (cmd.load_result) out_full_next = 1'b1;
    else if (out_full && !out_stall) out_full_next = 1'b0;
  end

  assign out_valid = out_full;

endmodule

[rtl/lmms_datapath.sv]
// datapath for the local maxima mean spacing block: peak tracking,
// gap accumulation and a bit-serial restoring divider
// depends on lmms_pkg

module lmms_datapath import lmms_pkg::*; #(
  parameter int MAX_LEN      = 8192,
  parameter int FRAC_BITS    = 8,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cmd_t                           cmd,
  output status_t                        status,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic [MEAN_W-1:0]              mean_gap,
  output logic                           found
);

  localparam int POS_W = $clog2(MAX_LEN);
  localparam int SUM_W = POS_W + 1;
  localparam int NUM_W = SUM_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int QW    = (NUM_W > MEAN_W) ? NUM_W : MEAN_W;

  logic signed [SAMPLE_WIDTH-1:0] older_sample;
  logic signed [SAMPLE_WIDTH-1:0] newer_sample;
  logic [POS_W-1:0]               position;
  logic [POS_W-1:0]               prior_peak_position;
  logic                           peak_seen;
  logic [SUM_W-1:0]               gap_sum;
  logic [POS_W-1:0]               gap_count;
  logic                           block_full;

  logic                           is_peak;
  logic [POS_W-1:0]               cand;
  logic [SUM_W-1:0]               gap_sum_next;
  logic [POS_W-1:0]               gap_count_next;

  logic [NUM_W-1:0]               num;
  logic [POS_W-1:0]               divisor;
  logic [POS_W-1:0]               rem;
  logic [CNT_W-1:0]               cnt;
  logic                           found_pend;
  logic [POS_W:0]                 trial;
  logic                           fits;
  logic [QW-1:0]                  q_ext;

  // peak check on the middle of the last three samples
  always_comb begin
    is_peak = !block_full && (position >= POS_W'(2)) &&
              (newer_sample > older_sample) && (newer_sample > sample);
    cand           = position - POS_W'(1);
    gap_sum_next   = gap_sum;
    gap_count_next = gap_count;
    if (is_peak && peak_seen) begin
      gap_sum_next   = gap_sum + SUM_W'(cand - prior_peak_position);
      gap_count_next = gap_count + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.start_div) begin
      older_sample        <= '0;
      newer_sample        <= '0;
      position            <= '0;
      prior_peak_position <= '0;
      peak_seen           <= 1'b0;
      gap_sum             <= '0;
      gap_count           <= '0;
      block_full          <= 1'b0;
    end else if (cmd.accept && !block_full) begin
      older_sample <= newer_sample;
      newer_sample <= sample;
      gap_sum      <= gap_sum_next;
      gap_count    <= gap_count_next;
      if (is_peak) begin
        prior_peak_position <= cand;
        peak_seen           <= 1'b1;
      end
      if (position == POS_W'(MAX_LEN - 1)) block_full <= 1'b1;
      else position <= position + POS_W'(1);
    end
  end

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem, num[NUM_W-1]};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.start_div) begin
      num        <= NUM_W'(gap_sum_next) << FRAC_BITS;
      divisor    <= gap_count_next;
      rem        <= '0;
      found_pend <= gap_count_next != '0;
      cnt        <= CNT_W'(NUM_W);
    end else if (cmd.div_step) begin
      rem <= fits ? POS_W'(trial - {1'b0, divisor}) : trial[POS_W-1:0];
      num <= {num[NUM_W-2:0], fits};
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign status.div_done = cnt == '0;
  assign q_ext           = QW'(num);

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      mean_gap <= found_pend ? q_ext[MEAN_W-1:0] : '0;
      found    <= found_pend;
    end
  end

endmodule

[rtl/local_maxima_mean_spacing_core.sv]
// Local maxima mean spacing core.
// Input channel: sample/last words with in_valid, in_stall; a word is taken at
// a clock edge with in_valid high and in_stall low. last marks the final word
// of a block. Output channel: mean_gap/found with out_valid, out_stall.
// Peak detection and gap accumulation run at one word per cycle while
// in_stall is low. A word with last starts a bit-serial restoring divide
// of gap_sum << FRAC_BITS by the gap count, one quotient bit per cycle,
// and in_stall stays high until the divide is done and the result loaded.
// mean_gap is the truncated mean gap with FRAC_BITS fraction bits; found is
// 0, with mean_gap 0, when fewer than two maxima were seen in the block.
// Peak state clears as soon as last is taken, so the next block may stream in
// while a result waits. While the receiver stalls, the result holds, and a
// further last word is stalled until the waiting result is taken.
// Samples beyond MAX_LEN in one block are ignored for peak detection.
// Reset (rst, synchronous) clears all block state and drops out_valid.
// depends on lmms_pkg, lmms_ctrl, lmms_datapath

module local_maxima_mean_spacing_core import lmms_pkg::*; #(
  parameter int MAX_LEN      = 8192,
  parameter int FRAC_BITS    = 8,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [MEAN_W-1:0]              mean_gap,
  output logic                           found
);

  cmd_t    cmd;
  status_t status;

  lmms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  lmms_datapath #(
    .MAX_LEN      (MAX_LEN),
    .FRAC_BITS    (FRAC_BITS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .sample   (sample),
    .mean_gap (mean_gap),
    .found    (found)
  );

endmodule
